/* rtl/stok_pkg.sv */
package stok_pkg;

    localparam int LINE_W = 20;
    localparam int COL_W  = 16;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

    // token kinds
    localparam logic [3:0] K_DOC    = 4'd0;
    localparam logic [3:0] K_LINE   = 4'd1;
    localparam logic [3:0] K_BLOCK  = 4'd2;
    localparam logic [3:0] K_QUOTE  = 4'd3;
    localparam logic [3:0] K_LPAREN = 4'd4;
    localparam logic [3:0] K_RPAREN = 4'd5;
    localparam logic [3:0] K_IDENT  = 4'd6;
    localparam logic [3:0] K_NL     = 4'd7;
    localparam logic [3:0] K_BLANK  = 4'd8;
    localparam logic [3:0] K_STRING = 4'd9;
    localparam logic [3:0] K_END    = 4'd10;
    localparam logic [3:0] K_SBYTE  = 4'd11;
    localparam logic [3:0] K_ERROR  = 4'd12;
    localparam logic [3:0] K_NONE   = 4'd15;

    // error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_BAD_CHAR  = 3'd1;
    localparam logic [2:0] E_NL_STR    = 3'd2;
    localparam logic [2:0] E_UNT_STR   = 3'd3;
    localparam logic [2:0] E_BAD_ESC   = 3'd4;
    localparam logic [2:0] E_UNT_CMT   = 3'd5;

    typedef enum logic [3:0] {
        M_INIT, M_RUN, M_SLASH, M_SLASH2, M_LINE, M_BLOCK, M_BSTAR,
        M_STRING, M_ESCAPE, M_OCT, M_HEXX, M_HEX
    } mode_t;

    // one result item
    typedef struct packed {
        logic [3:0]        kind;
        logic [2:0]        err;
        logic [7:0]        sbyte;
        logic [LINE_W-1:0] bl;
        logic [COL_W-1:0]  bc;
        logic [LINE_W-1:0] el;
        logic [COL_W-1:0]  ec;
    } tok_t;

    // what one step produces
    typedef struct packed {
        logic [1:0] count;
        tok_t       t0;
        tok_t       t1;
    } step_t;

    function automatic logic is_id_start(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
               b == 8'h5f || b[7];
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == 8'h20 || b == 8'h0d || b == 8'h09;
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h37;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (is_digit(b))
            v = b - 8'h30;
        else if (b >= 8'h61)
            v = b - 8'h57;
        else
            v = b - 8'h37;
        return v[3:0];
    endfunction

endpackage

/* rtl/stok_core.sv */
// Lexer state and next-result logic: one byte per cycle while step is high.
module stok_core
    import stok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output step_t      result
);

    mode_t             mode_reg, mode_next;
    logic [LINE_W-1:0] line_reg, line_next, sl_reg, sl_next;
    logic [COL_W-1:0]  col_reg, col_next, sc_reg, sc_next;
    logic [3:0]        pend_reg, pend_next;
    logic [7:0]        eval_reg, eval_next;
    logic [1:0]        ecnt_reg, ecnt_next;
    logic              halt_reg, halt_next;

    always_comb
    begin
        logic [LINE_W-1:0] al;
        logic [COL_W-1:0]  ac;
        logic [7:0]        b;
        logic [7:0]        ev;
        logic              do_init;
        logic              do_str;
        tok_t              tk;

        b = data_byte;
        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        sl_next   = sl_reg;
        sc_next   = sc_reg;
        pend_next = pend_reg;
        eval_next = eval_reg;
        ecnt_next = ecnt_reg;
        halt_next = halt_reg;
        result    = '0;
        do_init   = 1'b0;
        do_str    = 1'b0;
        ev        = 8'd0;
        tk        = '0;

        // position after this byte
        if (b == 8'h0a)
        begin
            al = (line_reg != LINE_MAX) ? line_reg + 1'b1 : LINE_MAX;
            ac = '0;
        end
        else
        begin
            al = line_reg;
            ac = (col_reg != COL_MAX) ? col_reg + 1'b1 : COL_MAX;
        end

        if (halt_reg)
        begin
            result.count = 2'd0;
        end
        else if (end_of_input)
        begin
            tk.bl = sl_reg;
            tk.bc = sc_reg;
            tk.el = line_reg;
            tk.ec = col_reg;
            halt_next = 1'b1;
            case (mode_reg)
                M_RUN, M_LINE:
                begin
                    tk.kind = pend_reg;
                    result.t0 = tk;
                    result.count = 2'd1;
                end
                M_SLASH2:
                begin
                    tk.kind = K_LINE;
                    result.t0 = tk;
                    result.count = 2'd1;
                end
                M_SLASH:
                begin
                    tk.kind = K_ERROR;
                    tk.err = E_BAD_CHAR;
                    result.t0 = tk;
                    result.count = 2'd1;
                end
                M_BLOCK, M_BSTAR:
                begin
                    tk.kind = K_ERROR;
                    tk.err = E_UNT_CMT;
                    result.t0 = tk;
                    result.count = 2'd1;
                end
                M_OCT, M_HEX:
                begin
                    tk.kind = K_SBYTE;
                    tk.sbyte = eval_reg;
                    result.t0 = tk;
                    tk.sbyte = 8'd0;
                    tk.kind = K_ERROR;
                    tk.err = E_UNT_STR;
                    result.t1 = tk;
                    result.count = 2'd2;
                end
                M_STRING, M_ESCAPE, M_HEXX:
                begin
                    tk.kind = K_ERROR;
                    tk.err = E_UNT_STR;
                    result.t0 = tk;
                    result.count = 2'd1;
                end
                default:
                begin
                    result.count = 2'd0;
                end
            endcase
            // end token follows the flushed token, if any, when no error occurred
            if (mode_reg == M_INIT || mode_reg == M_RUN || mode_reg == M_SLASH2 ||
                mode_reg == M_LINE)
            begin
                tk = '0;
                tk.kind = K_END;
                tk.bl = line_reg;
                tk.bc = col_reg;
                tk.el = line_reg;
                tk.ec = col_reg;
                if (result.count == 2'd0)
                    result.t0 = tk;
                else
                    result.t1 = tk;
                result.count = result.count + 2'd1;
            end
        end
        else
        begin
            // token ended at the current position (pre-byte)
            tk.bl = sl_reg;
            tk.bc = sc_reg;
            tk.el = line_reg;
            tk.ec = col_reg;
            case (mode_reg)
                M_INIT:
                    do_init = 1'b1;
                M_RUN:
                begin
                    if (!((pend_reg == K_IDENT && (is_id_start(b) || is_digit(b))) ||
                          (pend_reg == K_BLANK && is_blank(b))))
                    begin
                        tk.kind = pend_reg;
                        result.t0 = tk;
                        result.count = 2'd1;
                        pend_next = K_NONE;
                        mode_next = M_INIT;
                        do_init = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (b == 8'h2f)
                        mode_next = M_SLASH2;
                    else if (b == 8'h2a)
                    begin
                        mode_next = M_BLOCK;
                        pend_next = K_BLOCK;
                    end
                    else
                    begin
                        tk.kind = K_ERROR;
                        tk.err = E_BAD_CHAR;
                        result.t0 = tk;
                        result.count = 2'd1;
                        halt_next = 1'b1;
                    end
                end
                M_SLASH2:
                begin
                    mode_next = M_LINE;
                    if (b == 8'h2f)
                        pend_next = K_DOC;
                    else if (b == 8'h0a)
                    begin
                        tk.kind = K_LINE;
                        tk.el = al;
                        tk.ec = ac;
                        result.t0 = tk;
                        result.count = 2'd1;
                        pend_next = K_NONE;
                        mode_next = M_INIT;
                    end
                    else
                        pend_next = K_LINE;
                end
                M_LINE:
                begin
                    if (b == 8'h0a)
                    begin
                        tk.kind = pend_reg;
                        tk.el = al;
                        tk.ec = ac;
                        result.t0 = tk;
                        result.count = 2'd1;
                        pend_next = K_NONE;
                        mode_next = M_INIT;
                    end
                end
                M_BLOCK:
                    if (b == 8'h2a)
                        mode_next = M_BSTAR;
                M_BSTAR:
                begin
                    if (b == 8'h2f)
                    begin
                        tk.kind = K_BLOCK;
                        tk.el = al;
                        tk.ec = ac;
                        result.t0 = tk;
                        result.count = 2'd1;
                        pend_next = K_NONE;
                        mode_next = M_INIT;
                    end
                    else if (b != 8'h2a)
                        mode_next = M_BLOCK;
                end
                M_STRING:
                    do_str = 1'b1;
                M_ESCAPE:
                begin
                    tk.el = al;
                    tk.ec = ac;
                    tk.kind = K_SBYTE;
                    mode_next = M_STRING;
                    result.count = 2'd1;
                    case (b)
                        8'h27: tk.sbyte = 8'h27;
                        8'h22: tk.sbyte = 8'h22;
                        8'h3f: tk.sbyte = 8'h3f;
                        8'h5c: tk.sbyte = 8'h5c;
                        8'h61: tk.sbyte = 8'd7;
                        8'h62: tk.sbyte = 8'd8;
                        8'h66: tk.sbyte = 8'd12;
                        8'h6e: tk.sbyte = 8'd10;
                        8'h72: tk.sbyte = 8'd13;
                        8'h74: tk.sbyte = 8'd9;
                        8'h76: tk.sbyte = 8'd11;
                        default:
                        begin
                            result.count = 2'd0;
                            if (is_oct(b))
                            begin
                                eval_next = {5'd0, b[2:0]};
                                ecnt_next = 2'd1;
                                mode_next = M_OCT;
                            end
                            else if (b == 8'h78 || b == 8'h58)
                            begin
                                eval_next = 8'd0;
                                ecnt_next = 2'd0;
                                mode_next = M_HEXX;
                            end
                            else
                            begin
                                tk.kind = K_ERROR;
                                tk.err = E_BAD_ESC;
                                result.count = 2'd1;
                                halt_next = 1'b1;
                                mode_next = M_ESCAPE;
                            end
                        end
                    endcase
                    result.t0 = tk;
                end
                M_OCT:
                begin
                    if (is_oct(b) && ecnt_reg < 2'd3)
                    begin
                        ev = {eval_reg[4:0], b[2:0]};
                        eval_next = ev;
                        ecnt_next = ecnt_reg + 2'd1;
                        if (ecnt_reg == 2'd2)
                        begin
                            tk.kind = K_SBYTE;
                            tk.sbyte = ev;
                            tk.el = al;
                            tk.ec = ac;
                            result.t0 = tk;
                            result.count = 2'd1;
                            mode_next = M_STRING;
                        end
                    end
                    else
                    begin
                        tk.kind = K_SBYTE;
                        tk.sbyte = eval_reg;
                        result.t0 = tk;
                        result.count = 2'd1;
                        mode_next = M_STRING;
                        do_str = 1'b1;
                    end
                end
                M_HEXX:
                begin
                    if (is_hex(b))
                    begin
                        eval_next = {4'd0, hex_val(b)};
                        ecnt_next = 2'd1;
                        mode_next = M_HEX;
                    end
                    else
                    begin
                        tk.kind = K_ERROR;
                        tk.err = E_BAD_ESC;
                        tk.el = al;
                        tk.ec = ac;
                        result.t0 = tk;
                        result.count = 2'd1;
                        halt_next = 1'b1;
                    end
                end
                M_HEX:
                begin
                    if (is_hex(b))
                    begin
                        ev = {eval_reg[3:0], hex_val(b)};
                        eval_next = ev;
                        ecnt_next = 2'd2;
                        tk.kind = K_SBYTE;
                        tk.sbyte = ev;
                        tk.el = al;
                        tk.ec = ac;
                        result.t0 = tk;
                        result.count = 2'd1;
                        mode_next = M_STRING;
                    end
                    else
                    begin
                        tk.kind = K_SBYTE;
                        tk.sbyte = eval_reg;
                        result.t0 = tk;
                        result.count = 2'd1;
                        mode_next = M_STRING;
                        do_str = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = M_INIT;
                    do_init = 1'b1;
                end
            endcase

            // byte at token start
            if (do_init)
            begin
                tk = '0;
                tk.bl = line_reg;
                tk.bc = col_reg;
                tk.el = al;
                tk.ec = ac;
                sl_next = line_reg;
                sc_next = col_reg;
                if (b == 8'h2f)
                    mode_next = M_SLASH;
                else if (b == 8'h27)
                    tk.kind = K_QUOTE;
                else if (b == 8'h28)
                    tk.kind = K_LPAREN;
                else if (b == 8'h29)
                    tk.kind = K_RPAREN;
                else if (is_id_start(b))
                begin
                    mode_next = M_RUN;
                    pend_next = K_IDENT;
                end
                else if (b == 8'h22)
                    mode_next = M_STRING;
                else if (b == 8'h0a)
                    tk.kind = K_NL;
                else if (is_blank(b))
                begin
                    mode_next = M_RUN;
                    pend_next = K_BLANK;
                end
                else
                begin
                    tk.kind = K_ERROR;
                    tk.err = E_BAD_CHAR;
                    halt_next = 1'b1;
                end
                if (b == 8'h27 || b == 8'h28 || b == 8'h29 || b == 8'h0a ||
                    !(b == 8'h2f || is_id_start(b) || b == 8'h22 || is_blank(b)))
                begin
                    if (result.count == 2'd0)
                        result.t0 = tk;
                    else
                        result.t1 = tk;
                    result.count = result.count + 2'd1;
                end
            end

            // byte inside a string literal
            if (do_str)
            begin
                tk = '0;
                tk.bl = sl_reg;
                tk.bc = sc_reg;
                tk.el = al;
                tk.ec = ac;
                if (b == 8'h22)
                begin
                    tk.kind = K_STRING;
                    mode_next = M_INIT;
                end
                else if (b == 8'h5c)
                    mode_next = M_ESCAPE;
                else if (b == 8'h0a)
                begin
                    tk.kind = K_ERROR;
                    tk.err = E_NL_STR;
                    halt_next = 1'b1;
                end
                else
                begin
                    tk.kind = K_SBYTE;
                    tk.sbyte = b;
                end
                if (b != 8'h5c)
                begin
                    if (result.count == 2'd0)
                        result.t0 = tk;
                    else
                        result.t1 = tk;
                    result.count = result.count + 2'd1;
                end
            end

            line_next = al;
            col_next  = ac;
        end
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_INIT;
            line_reg <= '0;
            col_reg  <= '0;
            sl_reg   <= '0;
            sc_reg   <= '0;
            pend_reg <= K_NONE;
            eval_reg <= '0;
            ecnt_reg <= '0;
            halt_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            sl_reg   <= sl_next;
            sc_reg   <= sc_next;
            pend_reg <= pend_next;
            eval_reg <= eval_next;
            ecnt_reg <= ecnt_next;
            halt_reg <= halt_next;
        end
    end

endmodule

/* rtl/stok_outq.sv */
// Output queue: up to four tokens, fed up to two at a time, drained one per cycle while pop is high.
module stok_outq
    import stok_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  step_t wr,
    output logic  space,
    output logic  out_valid,
    output tok_t  out_tok,
    output logic  out_last,
    input  logic  pop
);

    tok_t       slot_reg [4];
    logic [3:0] last_reg;
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;

    logic [2:0] cnt_after_pop;

    assign cnt_after_pop = cnt_reg - {2'd0, pop};
    // at least two free slots after the pop in this cycle
    assign space     = cnt_after_pop <= 3'd2;
    assign out_valid = cnt_reg != 3'd0;
    assign out_tok   = slot_reg[rd_reg];
    assign out_last  = last_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && wr.count != 2'd0)
        begin
            slot_reg[wr_reg] <= wr.t0;
            if (wr.count == 2'd2)
                slot_reg[wr_reg + 2'd1] <= wr.t1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            rd_reg   <= '0;
            wr_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push && wr.count != 2'd0)
            begin
                last_reg[wr_reg] <= (wr.count == 2'd1);
                if (wr.count == 2'd2)
                    last_reg[wr_reg + 2'd1] <= 1'b1;
                wr_reg <= wr_reg + wr.count;
            end
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_after_pop + (push ? {1'b0, wr.count} : 3'd0);
        end
    end

endmodule

/* rtl/source_tokenizer_with_string_escapes.sv */
// A token is written into the queue when the byte that completes it is accepted.
// Throughput: one byte or end marker per cycle while in_stall is low; a step giving two
// tokens drains them one at a time through the single-token output port of the 4-entry queue.
// Reset (rst_n, async, active low) returns the lexer to its initial mode at
// line 0, column 0, clears the halt flag and empties the queue.
module source_tokenizer_with_string_escapes
    import stok_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [3:0]        token_kind,
    output logic [2:0]        error_code,
    output logic [7:0]        string_byte,
    output logic [LINE_W-1:0] begin_line,
    output logic [COL_W-1:0]  begin_column,
    output logic [LINE_W-1:0] end_line,
    output logic [COL_W-1:0]  end_column,
    output logic              last_of_run
);

    step_t res;
    tok_t  tok;
    logic  space, step, pop;

    assign in_stall = !space;
    assign step     = in_valid && space;
    assign pop      = out_valid && !out_stall;

    stok_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .result       (res)
    );

    stok_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .wr        (res),
        .space     (space),
        .out_valid (out_valid),
        .out_tok   (tok),
        .out_last  (last_of_run),
        .pop       (pop)
    );

    assign token_kind   = tok.kind;
    assign error_code   = tok.err;
    assign string_byte  = tok.sbyte;
    assign begin_line   = tok.bl;
    assign begin_column = tok.bc;
    assign end_line     = tok.el;
    assign end_column   = tok.ec;

endmodule

/* rtl/stok_checker.sv */
module stok_checker
    import stok_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] token_kind,
    input logic [2:0] error_code,
    input logic [7:0] string_byte
);

    // stalled token holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind))
        else $error("stalled token changed");

    // error code only on error tokens
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != K_ERROR |-> error_code == E_NONE)
        else $error("error code on non-error token");

    // string byte only on string byte tokens
    a_sb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != K_SBYTE |-> string_byte == 8'd0)
        else $error("string byte on other token");

    // kinds above error never appear
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= K_ERROR)
        else $error("bad token kind");

endmodule

bind source_tokenizer_with_string_escapes stok_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .error_code  (error_code),
    .string_byte (string_byte)
);
